// File: sv/motor_command_packet_decoder_defines.svh
// Assertion macros shared by the motor command packet decoder RTL.
// Expects signals clk and rst in the scope where a macro is used.
`ifndef MOTOR_COMMAND_PACKET_DECODER_DEFINES_SVH
`define MOTOR_COMMAND_PACKET_DECODER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MCPD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MCPD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/mcpd_pkg.sv
// Types and constants for the motor command packet decoder.
// No dependencies; imported by mcpd_drive and the top level.
`default_nettype none

package mcpd_pkg;

  // Register indexes of the configuration port
  localparam logic [1:0] CFG_HEADER_VALUE = 2'd0;
  localparam logic [1:0] CFG_DEAD_ZONE    = 2'd1;

  localparam logic [7:0] HEADER_RESET    = 8'd170;
  localparam logic [6:0] DEAD_ZONE_RESET = 7'd10;

  localparam logic [6:0] MAG_LIMIT = 7'd100;
  localparam logic [7:0] FULL_DUTY = 8'd255;
  // duty = mag*255/100 == (mag * DUTY_RECIP) >> DUTY_SHIFT for mag 0..100
  localparam int         DUTY_SHIFT = 19;
  localparam logic [27:0] DUTY_RECIP = 28'd1336965;

  // Result queue
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    POS_HUNT,
    POS_THROTTLE,
    POS_RUDDER,
    POS_CHECKSUM
  } byte_pos_t;

  typedef struct packed {
    logic [7:0] forward_duty;
    logic [7:0] backward_duty;
    logic [7:0] rudder_setting;
    logic       kick_pulse;
    logic       last_of_run;
  } result_t;

  // Outcome of one good packet
  typedef struct packed {
    result_t first;
    result_t second;
    logic    two;           // second entry is valid (kick came first)
    logic    stopped_next;
  } drive_out_t;

endpackage

`default_nettype wire

// File: sv/motor_command_packet_decoder.sv
// Motor command packet decoder: one received byte per beat in, zero to two
// results per beat out. Depends on mcpd_pkg, mcpd_drive and the defines header.
`default_nettype none

// A packet is a header byte, a signed throttle byte, a rudder byte and a
// checksum (header ^ throttle ^ rudder). Bytes before a header are dropped, and
// a packet with a bad checksum is dropped whole. A good packet yields one drive
// result, preceded by a full-duty kick result when a stopped motor is restarted;
// the last result of a packet has last_of_run set. Throughput is one byte per
// unstalled cycle: each byte is decoded in the cycle it is accepted and its
// results are written into a four-entry result queue that the output port drains
// one beat per unstalled cycle. in_stall rises while fewer than two queue
// entries are free, so a byte can always place both of its results. Bytes that
// complete nothing never touch the queue. The header value and dead zone are
// written through the cfg port (index 0 and 1; other indexes are ignored) and
// must only change while the decoder is idle. cfg_ready is always high.

module motor_command_packet_decoder (
  input  wire logic       clk,
  input  wire logic       rst,
  // byte input
  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire logic [7:0] rx_byte,
  // result output
  output      logic       out_valid,
  input  wire logic       out_stall,
  output      logic [7:0] forward_duty,
  output      logic [7:0] backward_duty,
  output      logic [7:0] rudder_setting,
  output      logic       kick_pulse,
  output      logic       last_of_run,
  // configuration writes
  input  wire logic       cfg_valid,
  output      logic       cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);
  import mcpd_pkg::*;

  // config registers
  logic [7:0] header_value;
  logic [6:0] dead_zone;

  // packet state
  byte_pos_t  byte_position;
  logic [7:0] throttle_hold;
  logic [7:0] rudder_hold;
  logic       motor_stopped;

  // result queue
  result_t        q [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;
  logic [QAW:0]   count_next;
  logic [1:0]     push_n;

  logic       in_acc;
  logic       out_acc;
  logic       cks_ok;
  logic       push;
  drive_out_t drv;
  result_t    head;

  mcpd_drive u_drive (
    .throttle      (throttle_hold),
    .rudder        (rudder_hold),
    .dead_zone     (dead_zone),
    .motor_stopped (motor_stopped),
    .drv           (drv)
  );

  assign cfg_ready = 1'b1;

  // need room for a kick plus a drive result
  assign in_stall = (count > (QAW+1)'(QDEPTH - 2));
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;

  assign cks_ok = ((header_value ^ throttle_hold ^ rudder_hold) == rx_byte);
  assign push   = in_acc && (byte_position == POS_CHECKSUM) && cks_ok;
  assign push_n = push ? (drv.two ? 2'd2 : 2'd1) : 2'd0;

  assign count_next = count + {{(QAW-1){1'b0}}, push_n} - {{QAW{1'b0}}, out_acc};

  // output side
  assign head           = q[rd_ptr];
  assign out_valid      = (count != '0);
  assign forward_duty   = head.forward_duty;
  assign backward_duty  = head.backward_duty;
  assign rudder_setting = head.rudder_setting;
  assign kick_pulse     = head.kick_pulse;
  assign last_of_run    = head.last_of_run;

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      header_value <= HEADER_RESET;
      dead_zone    <= DEAD_ZONE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HEADER_VALUE: header_value <= cfg_data;
        CFG_DEAD_ZONE:    dead_zone    <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // packet framing
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= POS_HUNT;
      throttle_hold <= 8'd0;
      rudder_hold   <= 8'd0;
      motor_stopped <= 1'b1;
    end else if (in_acc) begin
      unique case (byte_position)
        POS_HUNT: begin
          if (rx_byte == header_value) byte_position <= POS_THROTTLE;
        end
        POS_THROTTLE: begin
          throttle_hold <= rx_byte;
          byte_position <= POS_RUDDER;
        end
        POS_RUDDER: begin
          rudder_hold   <= rx_byte;
          byte_position <= POS_CHECKSUM;
        end
        POS_CHECKSUM: begin
          byte_position <= POS_HUNT;
          if (cks_ok) motor_stopped <= drv.stopped_next;
        end
      endcase
    end
  end

  // queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QAW'(push_n);
      if (out_acc) rd_ptr <= rd_ptr + 1'b1;
      count <= count_next;
    end
  end

  // queue payload
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= drv.first;
      if (drv.two) q[wr_ptr + 1'b1] <= drv.second;
    end
  end

`include "motor_command_packet_decoder_defines.svh"

  `MCPD_ASSERT_IMP(a_count_bound, 1'b1, count <= (QAW+1)'(QDEPTH), "result queue overflow")
  `MCPD_ASSERT_NXT(a_good_packet_out, push, out_valid, "good packet gave no result")
  `MCPD_ASSERT_IMP(a_kick_followed, out_valid && kick_pulse, count >= (QAW+1)'(2), "kick without drive result behind it")
  `MCPD_ASSERT_NXT(a_no_spurious_push, in_acc && (byte_position != POS_CHECKSUM), count <= $past(count), "non-checksum byte queued a result")

endmodule

`default_nettype wire

// File: sv/mcpd_drive.sv
// Drive computation for one good packet: dead zone, saturation, duty, kick.
// Depends on mcpd_pkg.
`default_nettype none

module mcpd_drive (
  input  wire logic [7:0]         throttle,
  input  wire logic [7:0]         rudder,
  input  wire logic [6:0]         dead_zone,
  input  wire logic               motor_stopped,
  output mcpd_pkg::drive_out_t    drv
);
  import mcpd_pkg::*;

  logic        neg;
  logic        pos;
  logic [7:0]  mag;
  logic [6:0]  mag_sat;
  logic [27:0] prod;
  logic [7:0]  duty;
  result_t     run_res;
  result_t     kick_res;
  result_t     stop_res;

  assign neg     = throttle[7];
  assign pos     = !neg && (throttle != 8'd0);
  assign mag     = neg ? (8'd0 - throttle) : throttle;   // 128 wraps to 0x80, ok
  assign mag_sat = (mag > {1'b0, MAG_LIMIT}) ? MAG_LIMIT : mag[6:0];
  assign prod    = {21'd0, mag_sat} * DUTY_RECIP;
  assign duty    = prod[DUTY_SHIFT+7:DUTY_SHIFT];

  always_comb begin
    run_res.forward_duty   = neg ? 8'd0 : duty;
    run_res.backward_duty  = neg ? duty : 8'd0;
    run_res.rudder_setting = rudder;
    run_res.kick_pulse     = 1'b0;
    run_res.last_of_run    = 1'b1;

    // zero throttle kicks backward
    kick_res.forward_duty   = pos ? FULL_DUTY : 8'd0;
    kick_res.backward_duty  = pos ? 8'd0 : FULL_DUTY;
    kick_res.rudder_setting = rudder;
    kick_res.kick_pulse     = 1'b1;
    kick_res.last_of_run    = 1'b0;

    stop_res.forward_duty   = 8'd0;
    stop_res.backward_duty  = 8'd0;
    stop_res.rudder_setting = rudder;
    stop_res.kick_pulse     = 1'b0;
    stop_res.last_of_run    = 1'b1;

    if (mag < {1'b0, dead_zone}) begin
      drv.first        = stop_res;
      drv.second       = stop_res;
      drv.two          = 1'b0;
      drv.stopped_next = 1'b1;
    end else if (motor_stopped) begin
      drv.first        = kick_res;
      drv.second       = run_res;
      drv.two          = 1'b1;
      drv.stopped_next = 1'b0;
    end else begin
      drv.first        = run_res;
      drv.second       = run_res;
      drv.two          = 1'b0;
      drv.stopped_next = 1'b0;
    end
  end

endmodule

`default_nettype wire
